>>> rtl/core/ujse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ujse_pkg
// Shared types, codes and character constants of the UTF-8 validating JSON
// string escaper.
// ----------------------------------------------------------------------------
package ujse_pkg;

   // request function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_DATA  = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;

   // ascii characters used by the escapes
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;

   // control bytes with a letter escape
   localparam logic [7:0] BYTE_BS = 8'h08;
   localparam logic [7:0] BYTE_HT = 8'h09;
   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_FF = 8'h0C;
   localparam logic [7:0] BYTE_CR = 8'h0D;

   // utf-8 lead and continuation bounds
   localparam logic [7:0] BYTE_SPACE   = 8'h20;
   localparam logic [7:0] BYTE_HIGH    = 8'h80;
   localparam logic [7:0] LEAD2_LO     = 8'hC2;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF4;
   localparam logic [7:0] LEAD_SURR    = 8'hED;
   localparam logic [7:0] CONT_LO      = 8'h80;
   localparam logic [7:0] CONT_HI      = 8'hBF;
   localparam logic [7:0] CONT_E0_LO   = 8'hA0;
   localparam logic [7:0] CONT_ED_HI   = 8'h9F;
   localparam logic [7:0] CONT_F0_LO   = 8'h90;
   localparam logic [7:0] CONT_F4_HI   = 8'h8F;

   localparam int unsigned SLOTS = 4;

   // one output token: a raw byte, a two-byte escape, \u00xx or \uE0xx
   typedef enum logic [1:0] {
      TOK_RAW = 2'd0,
      TOK_ESC = 2'd1,
      TOK_U00 = 2'd2,
      TOK_UE0 = 2'd3
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   val;
   } tok_type;

   // all tokens caused by one request beat
   typedef struct packed {
      logic [2:0]              cnt;
      tok_type [SLOTS-1:0]     slot;
   } tok_list_type;

   // lowercase hex digit
   function automatic logic [7:0] hex_digit(input logic [3:0] d);
      logic [7:0] wide;
      wide = {4'b0000, d};
      if (d < 4'd10) begin
         hex_digit = CH_ZERO + wide;
      end else begin
         hex_digit = 8'h57 + wide;
      end
   endfunction

endpackage

>>> rtl/core/ujse_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ujse_decode
// Classifies each request beat, tracks the partial UTF-8 sequence and builds
// the list of output tokens that the beat causes.
// ----------------------------------------------------------------------------
module ujse_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            func,
   input  logic [7:0]            data_byte,
   output ujse_pkg::tok_list_type list
);
   import ujse_pkg::*;

   logic [7:0] held_ff [3];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [2:0] seq_len_ff, seq_len_in;

   logic       wr_en;
   logic [1:0] wr_idx;

   logic       fr_has, fr_lead;
   logic [2:0] fr_len;
   tok_type    fr_tok;

   logic [7:0] lo, hi;
   logic       cont_ok, complete;

   logic [1:0] flush_n;
   logic       flush_raw, has_final;
   tok_type    final_tok;

   // handling of a byte with nothing held
   always_comb begin
      fr_has = 1'b1;
      fr_lead = 1'b0;
      fr_len = 3'd0;
      fr_tok.kind = TOK_RAW;
      fr_tok.val = data_byte;
      if (data_byte == CH_QUOTE || data_byte == CH_BSLASH) begin
         fr_tok.kind = TOK_ESC;
      end else if (data_byte == BYTE_LF) begin
         fr_tok.kind = TOK_ESC;
         fr_tok.val = CH_LOW_N;
      end else if (data_byte == BYTE_CR) begin
         fr_tok.kind = TOK_ESC;
         fr_tok.val = CH_LOW_R;
      end else if (data_byte == BYTE_HT) begin
         fr_tok.kind = TOK_ESC;
         fr_tok.val = CH_LOW_T;
      end else if (data_byte == BYTE_BS) begin
         fr_tok.kind = TOK_ESC;
         fr_tok.val = CH_LOW_B;
      end else if (data_byte == BYTE_FF) begin
         fr_tok.kind = TOK_ESC;
         fr_tok.val = CH_LOW_F;
      end else if (data_byte < BYTE_SPACE) begin
         fr_tok.kind = TOK_U00;
      end else if (data_byte < BYTE_HIGH) begin
         fr_tok.kind = TOK_RAW;
      end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
         fr_has = 1'b0;
         fr_lead = 1'b1;
         fr_len = 3'd2;
      end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
         fr_has = 1'b0;
         fr_lead = 1'b1;
         fr_len = 3'd3;
      end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
         fr_has = 1'b0;
         fr_lead = 1'b1;
         fr_len = 3'd4;
      end else begin
         fr_tok.kind = TOK_UE0;
      end
   end

   // continuation range check, tighter on the first one after some leads
   always_comb begin
      lo = CONT_LO;
      hi = CONT_HI;
      if (held_cnt_ff == 2'd1) begin
         if (held_ff[0] == LEAD3_LO) begin
            lo = CONT_E0_LO;
         end else if (held_ff[0] == LEAD_SURR) begin
            hi = CONT_ED_HI;
         end else if (held_ff[0] == LEAD4_LO) begin
            lo = CONT_F0_LO;
         end else if (held_ff[0] == LEAD4_HI) begin
            hi = CONT_F4_HI;
         end
      end
      cont_ok = (data_byte >= lo) && (data_byte <= hi);
      complete = ({1'b0, held_cnt_ff} + 3'd1) >= seq_len_ff;
   end

   // per-function token selection and sequence state update
   always_comb begin
      flush_n = 2'd0;
      flush_raw = 1'b0;
      has_final = 1'b0;
      final_tok.kind = TOK_RAW;
      final_tok.val = CH_QUOTE;
      held_cnt_in = held_cnt_ff;
      seq_len_in = seq_len_ff;
      wr_en = 1'b0;
      wr_idx = held_cnt_ff;
      unique case (func)
         FUNC_START: begin
            has_final = 1'b1;
            held_cnt_in = 2'd0;
            seq_len_in = 3'd0;
         end
         FUNC_DATA: begin
            if (held_cnt_ff != 2'd0 && cont_ok) begin
               if (complete) begin
                  flush_n = held_cnt_ff;
                  flush_raw = 1'b1;
                  has_final = 1'b1;
                  final_tok.val = data_byte;
                  held_cnt_in = 2'd0;
                  seq_len_in = 3'd0;
               end else begin
                  wr_en = 1'b1;
                  held_cnt_in = held_cnt_ff + 2'd1;
               end
            end else begin
               flush_n = held_cnt_ff;
               has_final = fr_has;
               final_tok = fr_tok;
               if (fr_lead) begin
                  wr_en = 1'b1;
                  wr_idx = 2'd0;
                  held_cnt_in = 2'd1;
                  seq_len_in = fr_len;
               end else begin
                  held_cnt_in = 2'd0;
                  seq_len_in = 3'd0;
               end
            end
         end
         FUNC_END: begin
            flush_n = held_cnt_ff;
            has_final = 1'b1;
            held_cnt_in = 2'd0;
            seq_len_in = 3'd0;
         end
         default: begin
         end
      endcase
   end

   // held bytes fill the first slots, the closing token follows them
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         list.slot[i].kind = flush_raw ? TOK_RAW : TOK_UE0;
         list.slot[i].val = held_ff[i];
      end
      list.slot[SLOTS-1] = final_tok;
      list.slot[flush_n] = final_tok;
      list.cnt = {1'b0, flush_n} + {2'b00, has_final};
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         seq_len_ff <= 3'd0;
      end else if (accept) begin
         held_cnt_ff <= held_cnt_in;
         seq_len_ff <= seq_len_in;
      end
   end

   // held sequence bytes
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         held_ff[wr_idx] <= data_byte;
      end
   end

endmodule

>>> rtl/core/ujse_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ujse_emit
// Holds the token list of one request beat and spells it out one byte per
// cycle into the response register while that register is not stalled.
// ----------------------------------------------------------------------------
module ujse_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ujse_pkg::tok_list_type list,
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_last
);
   import ujse_pkg::*;

   tok_list_type list_ff;
   logic         list_valid_ff, list_valid_in;
   logic [1:0]   tok_idx_ff, tok_idx_in;
   logic [2:0]   pos_ff, pos_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff;
   logic         rsp_last_ff;

   tok_type      cur_tok;
   logic [2:0]   tok_len;
   logic [7:0]   cur_byte;
   logic         last_byte, last_tok, advance, done;

   // byte of the current token at the current position
   always_comb begin
      cur_tok = list_ff.slot[tok_idx_ff];
      unique case (cur_tok.kind)
         TOK_RAW: tok_len = 3'd1;
         TOK_ESC: tok_len = 3'd2;
         TOK_U00: tok_len = 3'd6;
         TOK_UE0: tok_len = 3'd6;
         default: tok_len = 3'd6;
      endcase
      case (pos_ff)
         3'd0:    cur_byte = (cur_tok.kind == TOK_RAW) ? cur_tok.val : CH_BSLASH;
         3'd1:    cur_byte = (cur_tok.kind == TOK_ESC) ? cur_tok.val : CH_LOW_U;
         3'd2:    cur_byte = (cur_tok.kind == TOK_U00) ? CH_ZERO : CH_UP_E;
         3'd3:    cur_byte = CH_ZERO;
         3'd4:    cur_byte = hex_digit(cur_tok.val[7:4]);
         default: cur_byte = hex_digit(cur_tok.val[3:0]);
      endcase
      last_byte = (pos_ff == (tok_len - 3'd1));
      last_tok = ({1'b0, tok_idx_ff} == (list_ff.cnt - 3'd1));
   end

   // step through the list whenever the response register frees up
   always_comb begin
      advance = list_valid_ff && (!rsp_valid_ff || !rsp_stall);
      done = advance && last_byte && last_tok;
      ready = !list_valid_ff || done;
      list_valid_in = list_valid_ff;
      tok_idx_in = tok_idx_ff;
      pos_in = pos_ff;
      if (advance) begin
         if (last_byte) begin
            pos_in = 3'd0;
            tok_idx_in = tok_idx_ff + 2'd1;
            if (last_tok) begin
               list_valid_in = 1'b0;
            end
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
      if (load) begin
         list_valid_in = 1'b1;
         tok_idx_in = 2'd0;
         pos_in = 3'd0;
      end
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // list control
   always_ff @(posedge clock) begin
      if (reset) begin
         list_valid_ff <= 1'b0;
         tok_idx_ff <= 2'd0;
         pos_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         list_valid_ff <= list_valid_in;
         tok_idx_ff <= tok_idx_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // list and response payload
   always_ff @(posedge clock) begin
      if (load) begin
         list_ff <= list;
      end
      if (advance) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= last_byte && last_tok;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

>>> rtl/core/utf8_validating_json_string_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validating_json_string_escaper
// Streams a byte string into its JSON-quoted form with UTF-8 validation.
// ----------------------------------------------------------------------------
// Request beats carry req_func (start, data byte, end) and req_data_byte.
// Each beat yields zero or more response beats of one escaped byte each;
// rsp_run_last marks the last byte caused by a request beat. A beat that
// only buffers a UTF-8 lead or continuation byte yields nothing.
// The first byte of a beat passes the emitter list register, then the
// response register. Throughput, while rsp_stall is low: one request beat
// per cycle while each yields at most one byte; a beat yielding more holds
// req_stall high until its last byte leaves, as the emitter spells out its
// tokens one byte per cycle (up to 24 bytes for a failed four-byte sequence).
// A request beat is taken in the cycle the last byte of the previous list
// leaves for the response register, so the two sides overlap.
// Reset clears the partial sequence and drops any pending response.
// While rsp_stall is high the response register holds its byte and the
// emitter pauses; the request side stalls once the emitter list is busy.
// ----------------------------------------------------------------------------
module utf8_validating_json_string_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);
   import ujse_pkg::*;

   tok_list_type list;
   logic         ready;
   logic         accept;

   // request beat handshake
   assign req_stall = !ready;
   assign accept = req_valid && ready;

   // classification and sequence tracking
   ujse_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .data_byte (req_data_byte),
      .list      (list)
   );

   // byte emitter and response register
   ujse_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (accept && (list.cnt != 3'd0)),
      .list         (list),
      .ready        (ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule
